// ----- hw/rtl/cnv_pkg.sv -----
// Shared types, widths and register codes of the 3x3 convolution block.
package cnv_pkg;

  localparam int MAX_SIDE_DEF = 1024;
  localparam int QUEUE_DEPTH  = 4;

  localparam int SIDE_W     = 11;
  localparam int UPPER_W    = 48;
  localparam int LOWER_W    = 24;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 8;
  localparam int NTAPS  = 9;
  localparam int PROD_W = 17;
  localparam int ROW_W  = 19;
  localparam int ACC_W  = 21;

  localparam logic [SIDE_W-1:0]       SIDE_RESET = 11'd1024;
  localparam logic signed [ACC_W-1:0] PIX_MAX    = 21'sd255;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_LOWER = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic command;
    pix_t pixel_in;
  } in_t;

  typedef struct packed {
    pix_t pixel_out;
    logic frame_end;
    logic run_end;
  } out_t;

  typedef struct packed {
    logic is_drain;
    logic fill;
    logic mid_bank;
    logic has_mid;
    logic has_top;
    logic emit_a;
    logic emit_b;
    logic seed;
    logic frame_end;
    pix_t pixel;
  } op_t;

endpackage

// ----- hw/rtl/cnv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cnv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/cnv_fifo.sv -----
// Short flip-flop queue between the request classifier and the datapath.
module cnv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

endmodule

// ----- hw/rtl/cnv_front.sv -----
// Request classifier: frame position counters and datapath operation build.
module cnv_front #(
  parameter int MAX_SIDE = cnv_pkg::MAX_SIDE_DEF,
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int AW = $clog2(MAX_SIDE)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cnv_pkg::in_t   in_data,
  input  logic [SW-1:0]  side_eff,
  input  logic           restart,
  input  logic           q_full,
  output logic           push,
  output cnv_pkg::op_t   push_op,
  output logic [AW-1:0]  push_col
);

  logic [SW-1:0] row_r, row_nxt;
  logic [SW-1:0] col_r, col_nxt;
  logic [SW-1:0] drn_r, drn_nxt;
  logic [SW-1:0] n_m1;
  logic [SW-1:0] drn_p1;
  logic [SW-1:0] dcol;
  logic          accept;
  logic          is_pixel;
  logic          pix_ok;
  logic          drn_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_pixel = (in_data.command == cnv_pkg::CMD_PIXEL);
  assign n_m1     = side_eff - SW'(1);
  assign pix_ok   = (row_r < side_eff) && (col_r < side_eff);
  assign drn_ok   = (row_r >= side_eff) && (drn_r < side_eff);
  assign drn_p1   = drn_r + SW'(1);
  assign dcol     = (drn_p1 < side_eff) ? drn_p1 : n_m1;
  assign push     = accept && (is_pixel ? pix_ok : drn_ok);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    drn_nxt = drn_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
      drn_nxt = '0;
    end else if (accept && is_pixel && pix_ok) begin
      if (col_r == n_m1) begin
        col_nxt = '0;
        row_nxt = row_r + SW'(1);
      end else begin
        col_nxt = col_r + SW'(1);
      end
    end else if (accept && !is_pixel && drn_ok) begin
      if (drn_r == n_m1) begin
        row_nxt = '0;
        col_nxt = '0;
        drn_nxt = '0;
      end else begin
        drn_nxt = drn_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      drn_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      drn_r <= drn_nxt;
    end
  end

  always_comb begin
    push_op.pixel = in_data.pixel_in;
    if (is_pixel) begin
      push_op.is_drain  = 1'b0;
      push_op.fill      = (col_r == '0);
      push_op.mid_bank  = ~row_r[0];
      push_op.has_mid   = (row_r >= SW'(1));
      push_op.has_top   = (row_r >= SW'(2));
      push_op.emit_a    = (row_r >= SW'(1)) && (col_r >= SW'(1));
      push_op.emit_b    = (row_r >= SW'(1)) && (col_r == n_m1);
      push_op.seed      = (row_r == n_m1) && (col_r == '0);
      push_op.frame_end = 1'b0;
      push_col          = col_r[AW-1:0];
    end else begin
      push_op.is_drain  = 1'b1;
      push_op.fill      = (drn_r == '0);
      push_op.mid_bank  = n_m1[0];
      push_op.has_mid   = 1'b1;
      push_op.has_top   = (side_eff >= SW'(2));
      push_op.emit_a    = 1'b1;
      push_op.emit_b    = 1'b0;
      push_op.seed      = 1'b0;
      push_op.frame_end = (drn_r == n_m1);
      push_col          = dcol[AW-1:0];
    end
  end

endmodule

// ----- hw/rtl/cnv_back.sv -----
// Datapath: line store banks, 3x3 window, multiply, sum and clamp pipeline.
module cnv_back #(
  parameter int MAX_SIDE = cnv_pkg::MAX_SIDE_DEF,
  localparam int AW = $clog2(MAX_SIDE)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  cnv_pkg::op_t                 q_op,
  input  logic [AW-1:0]                q_col,
  output logic                         q_pop,
  input  logic [cnv_pkg::UPPER_W-1:0]  coeffs_upper,
  input  logic [cnv_pkg::LOWER_W-1:0]  coeffs_lower,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cnv_pkg::out_t                out_data
);

  typedef logic [cnv_pkg::NTAPS-1:0][cnv_pkg::PIX_W-1:0] win_t;

  function automatic win_t win_fill(cnv_pkg::pix_t t, cnv_pkg::pix_t m, cnv_pkg::pix_t b);
    win_t w;
    for (int i = 0; i < 3; i++) begin
      w[i]     = t;
      w[3 + i] = m;
      w[6 + i] = b;
    end
    return w;
  endfunction

  function automatic win_t win_shift(win_t w_in, cnv_pkg::pix_t t, cnv_pkg::pix_t m,
                                     cnv_pkg::pix_t b);
    win_t w;
    w = w_in;
    for (int r = 0; r < 3; r++) begin
      w[3 * r]     = w_in[3 * r + 1];
      w[3 * r + 1] = w_in[3 * r + 2];
    end
    w[2] = t;
    w[5] = m;
    w[8] = b;
    return w;
  endfunction

  logic back_en;
  logic bubble_r, bubble_nxt;

  logic          w_vld_r;
  cnv_pkg::op_t  w_op_r;
  logic          w_ph2_r, w_ph2_nxt;

  cnv_pkg::pix_t bank0_rd, bank1_rd;
  cnv_pkg::pix_t rd_mid, rd_top;
  cnv_pkg::pix_t tv, mv, bv;
  cnv_pkg::pix_t seed_top_r, seed_mid_r;
  logic          seed_load;

  win_t win_r, win_nxt;
  logic e_vld_r, e_vld_nxt;
  logic e_fe_r, e_fe_nxt;
  logic e_re_r, e_re_nxt;

  logic [cnv_pkg::LOWER_W+cnv_pkg::UPPER_W-1:0] coeffs;
  logic signed [cnv_pkg::PROD_W-1:0] prod_r [cnv_pkg::NTAPS];
  logic p_vld_r, p_fe_r, p_re_r;

  logic signed [cnv_pkg::ROW_W-1:0] rsum_r [3];
  logic s_vld_r, s_fe_r, s_re_r;

  logic signed [cnv_pkg::ACC_W-1:0] acc;
  cnv_pkg::pix_t clamp;

  logic          out_valid_r;
  cnv_pkg::out_t out_data_r;

  assign back_en    = !out_valid_r || out_ready;
  assign q_pop      = back_en && q_valid && !bubble_r;
  assign bubble_nxt = q_pop && q_op.emit_b;

  cnv_ram #(.WIDTH(cnv_pkg::PIX_W), .DEPTH(MAX_SIDE)) u_bank0 (
    .clk     (clk),
    .wr_en   (q_pop && !q_op.is_drain && q_op.mid_bank),
    .wr_addr (q_col),
    .wr_data (q_op.pixel),
    .rd_en   (q_pop),
    .rd_addr (q_col),
    .rd_data (bank0_rd)
  );

  cnv_ram #(.WIDTH(cnv_pkg::PIX_W), .DEPTH(MAX_SIDE)) u_bank1 (
    .clk     (clk),
    .wr_en   (q_pop && !q_op.is_drain && !q_op.mid_bank),
    .wr_addr (q_col),
    .wr_data (q_op.pixel),
    .rd_en   (q_pop),
    .rd_addr (q_col),
    .rd_data (bank1_rd)
  );

  assign rd_mid = w_op_r.mid_bank ? bank1_rd : bank0_rd;
  assign rd_top = w_op_r.mid_bank ? bank0_rd : bank1_rd;

  always_comb begin
    if (w_op_r.is_drain) begin
      mv = rd_mid;
      bv = rd_mid;
    end else begin
      mv = w_op_r.has_mid ? rd_mid : w_op_r.pixel;
      bv = w_op_r.pixel;
    end
    tv = w_op_r.has_top ? rd_top : mv;
  end

  always_comb begin
    win_nxt   = win_r;
    e_vld_nxt = 1'b0;
    e_fe_nxt  = 1'b0;
    e_re_nxt  = 1'b0;
    w_ph2_nxt = 1'b0;
    seed_load = 1'b0;
    if (w_ph2_r) begin
      win_nxt   = win_shift(win_r, win_r[2], win_r[5], win_r[8]);
      e_vld_nxt = 1'b1;
      e_re_nxt  = 1'b1;
    end else if (w_vld_r) begin
      if (w_op_r.is_drain) begin
        if (w_op_r.fill) begin
          win_nxt = win_shift(win_fill(seed_top_r, seed_mid_r, seed_mid_r), tv, mv, bv);
        end else begin
          win_nxt = win_shift(win_r, tv, mv, bv);
        end
      end else if (w_op_r.fill) begin
        win_nxt = win_fill(tv, mv, bv);
      end else begin
        win_nxt = win_shift(win_r, tv, mv, bv);
      end
      e_vld_nxt = w_op_r.emit_a;
      e_fe_nxt  = w_op_r.frame_end;
      e_re_nxt  = !w_op_r.emit_b;
      w_ph2_nxt = w_op_r.emit_b;
      seed_load = !w_op_r.is_drain && w_op_r.seed;
    end
  end

  assign coeffs = {coeffs_lower, coeffs_upper};

  always_comb begin
    acc = cnv_pkg::ACC_W'(rsum_r[0]) + cnv_pkg::ACC_W'(rsum_r[1])
        + cnv_pkg::ACC_W'(rsum_r[2]);
    if (acc >= cnv_pkg::PIX_MAX) begin
      clamp = '1;
    end else if (acc <= 0) begin
      clamp = '0;
    end else begin
      clamp = acc[cnv_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bubble_r    <= 1'b0;
      w_vld_r     <= 1'b0;
      w_ph2_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      s_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      bubble_r    <= bubble_nxt;
      w_vld_r     <= q_pop;
      w_ph2_r     <= w_ph2_nxt;
      e_vld_r     <= e_vld_nxt;
      p_vld_r     <= e_vld_r;
      s_vld_r     <= p_vld_r;
      out_valid_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      w_op_r <= q_op;
      win_r  <= win_nxt;
      e_fe_r <= e_fe_nxt;
      e_re_r <= e_re_nxt;
      if (seed_load) begin
        seed_top_r <= mv;
        seed_mid_r <= bv;
      end
      for (int k = 0; k < cnv_pkg::NTAPS; k++) begin
        prod_r[k] <= $signed(coeffs[cnv_pkg::COEF_W*k +: cnv_pkg::COEF_W])
                   * $signed({1'b0, win_r[k]});
      end
      p_fe_r <= e_fe_r;
      p_re_r <= e_re_r;
      for (int r = 0; r < 3; r++) begin
        rsum_r[r] <= cnv_pkg::ROW_W'(prod_r[3 * r]) + cnv_pkg::ROW_W'(prod_r[3 * r + 1])
                   + cnv_pkg::ROW_W'(prod_r[3 * r + 2]);
      end
      s_fe_r <= p_fe_r;
      s_re_r <= p_re_r;
      out_data_r.pixel_out <= clamp;
      out_data_r.frame_end <= s_fe_r;
      out_data_r.run_end   <= s_re_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/conv3x3_replicate_clamp.sv -----
// Top level of the 3x3 convolution with replicated borders and clamping.
// A request passes the queue, then the window, product, row-sum and output registers.
// Throughput: one request per cycle while the output is not stalled; a row-end pixel
// with two results puts a bubble in the window stage, so the next request waits.
// Reset: synchronous; counters, queue and pipeline valids clear, side_length = 1024,
// coefficients = 0; the line store holds no reset value and needs no clearing pass.
module conv3x3_replicate_clamp #(
  parameter int MAX_SIDE = cnv_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cnv_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cnv_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [cnv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cnv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = $clog2(MAX_SIDE);
  localparam int QW = $bits(cnv_pkg::op_t) + AW;

  logic [cnv_pkg::SIDE_W-1:0]  side_length_r;
  logic [cnv_pkg::UPPER_W-1:0] coeffs_upper_r;
  logic [cnv_pkg::LOWER_W-1:0] coeffs_lower_r;

  logic [31:0]   side_ext;
  logic [31:0]   side_clamp;
  logic [SW-1:0] side_eff;
  logic          restart;

  logic          push;
  cnv_pkg::op_t  push_op;
  logic [AW-1:0] push_col;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_rd;
  cnv_pkg::op_t  q_op;
  logic [AW-1:0] q_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_length_r  <= cnv_pkg::SIDE_RESET;
      coeffs_upper_r <= '0;
      coeffs_lower_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cnv_pkg::CFG_SIDE_LENGTH: begin
          side_length_r <= cfg_wdata[cnv_pkg::SIDE_W-1:0];
        end
        cnv_pkg::CFG_COEFFS_UPPER: begin
          coeffs_upper_r <= cfg_wdata[cnv_pkg::UPPER_W-1:0];
        end
        cnv_pkg::CFG_COEFFS_LOWER: begin
          coeffs_lower_r <= cfg_wdata[cnv_pkg::LOWER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign restart  = cfg_we && (cfg_index == cnv_pkg::CFG_SIDE_LENGTH);
  assign side_ext = 32'(side_length_r);

  always_comb begin
    if (side_ext == 32'd0) begin
      side_clamp = 32'd1;
    end else if (side_ext > 32'(MAX_SIDE)) begin
      side_clamp = 32'(MAX_SIDE);
    end else begin
      side_clamp = side_ext;
    end
  end

  assign side_eff = side_clamp[SW-1:0];

  cnv_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .side_eff (side_eff),
    .restart  (restart),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op),
    .push_col (push_col)
  );

  cnv_fifo #(.WIDTH(QW), .DEPTH(cnv_pkg::QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data ({push_col, push_op}),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd)
  );

  assign q_op  = q_rd[$bits(cnv_pkg::op_t)-1:0];
  assign q_col = q_rd[QW-1:$bits(cnv_pkg::op_t)];

  cnv_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_col        (q_col),
    .q_pop        (q_pop),
    .coeffs_upper (coeffs_upper_r),
    .coeffs_lower (coeffs_lower_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.run_end)
    else $error("frame end flagged on a result that does not close its request");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request pushed into a full queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
